// ===== hdl/ssvg_pkg.sv =====
package ssvg_pkg;

	// field widths
	localparam int MAG_W   = 16;
	localparam int GAIN_W  = 9;
	localparam int THR_W   = 28;
	localparam int POWER_W = 24;
	localparam int FRAC_W  = 8;

	// stream and configuration port widths
	localparam int IN_DATA_W  = 2 * MAG_W;
	localparam int OUT_DATA_W = MAG_W + POWER_W;
	localparam int OUT_USER_W = 1;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = THR_W;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND_GAIN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOUND_THRESHOLD   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SILENCE_THRESHOLD = 2'd2;

	// register reset values
	localparam logic [GAIN_W-1:0] GAIN_RESET        = 9'd205;
	localparam logic [THR_W-1:0]  SOUND_THR_RESET   = 28'd10240;
	localparam logic [THR_W-1:0]  SILENCE_THR_RESET = 28'd2560;

	typedef logic [MAG_W-1:0]   mag_t;
	typedef logic [POWER_W-1:0] power_t;
	typedef logic [THR_W-1:0]   thr_t;

endpackage

// ===== hdl/spectral_subtract_smooth_voice_gate_unit.sv =====
// Channel  | Dir | Item fields (lowest bit up)                      | Handshake
// s_*      | in  | tdata: voice_magnitude, background_magnitude     | s_tvalid & s_tready
// m_*      | out | tdata: smoothed_bin, frame_power; tlast: frame_end;
//          |     | tuser: trigger                                   | m_tvalid & m_tready
// cfg_wr_* | in  | index 0 gain, 1 sound thr, 2 silence thr         | cfg_wr_en
//
// One item per clock sustained while m_tready holds; m_tvalid rises once the
// item has passed four register stages (input/row read, subtract and frame sum,
// reciprocal divide, power and window update).
// The bin row memory is read-modify-written once per item, one port each way.
// Reset clears all control state at once; the smoothing memory gets no clearing
// pass, a saturating frame count masks rows of frames not yet written.
// A stall on m_tready backs up through the four stages to s_tready.
module spectral_subtract_smooth_voice_gate_unit #(
	parameter int BINS           = 256,
	parameter int AVG_FRAMES     = 4,
	parameter int HISTORY_FRAMES = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [ssvg_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
	input  logic [ssvg_pkg::CFG_DATA_W-1:0] cfg_wr_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// voice_magnitude [15:0], background_magnitude [31:16]
	input  logic [ssvg_pkg::IN_DATA_W-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// smoothed_bin [15:0], frame_power [39:16]
	output logic [ssvg_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                            m_tlast,
	// trigger [0]
	output logic [ssvg_pkg::OUT_USER_W-1:0] m_tuser
);
	import ssvg_pkg::*;

	localparam int BIN_W    = $clog2(BINS);
	localparam int SLOT_W   = $clog2(AVG_FRAMES);
	localparam int FILL_W   = $clog2(AVG_FRAMES + 1);
	localparam int ROW_W    = AVG_FRAMES * MAG_W;
	localparam int AVG_L    = $clog2(AVG_FRAMES);
	localparam int SUM_W    = MAG_W + AVG_L;
	// floor(n / AVG_FRAMES) = (n * RECIP) >> RECIP_SH, exact for n < 2**SUM_W
	localparam int RECIP_SH = SUM_W + AVG_L;
	localparam int RECIP_I  = (2 ** RECIP_SH + AVG_FRAMES - 1) / AVG_FRAMES;
	localparam logic [SUM_W:0] RECIP = RECIP_I[SUM_W:0];
	localparam int PROD_W   = 2 * SUM_W + 1;
	localparam int LEAD_END = HISTORY_FRAMES / 4;
	localparam int MID_END  = (HISTORY_FRAMES * 3) / 4;
	localparam int WIN_W    = POWER_W + $clog2(HISTORY_FRAMES);
	localparam int CMP_W    = (WIN_W > THR_W) ? WIN_W : THR_W;
	localparam logic [BIN_W-1:0]  BIN_LAST  = BIN_W'(BINS - 1);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(AVG_FRAMES - 1);
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(AVG_FRAMES);

	// configuration
	logic [GAIN_W-1:0] gain_q;
	thr_t              sound_thr_q;
	thr_t              silence_thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q        <= GAIN_RESET;
			sound_thr_q   <= SOUND_THR_RESET;
			silence_thr_q <= SILENCE_THR_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_wr_index)
				REG_BACKGROUND_GAIN:   gain_q        <= cfg_wr_data[GAIN_W-1:0];
				REG_SOUND_THRESHOLD:   sound_thr_q   <= cfg_wr_data[THR_W-1:0];
				REG_SILENCE_THRESHOLD: silence_thr_q <= cfg_wr_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// stage handshake: each stage loads when empty or when it moves on
	logic v1_s1, v2_s2, v3_s3, v4_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	logic accept, fire1, fire3;

	assign rdy4     = !v4_s4 || m_tready;
	assign rdy3     = !v3_s3 || rdy4;
	assign rdy2     = !v2_s2 || rdy3;
	assign rdy1     = !v1_s1 || rdy2;
	assign s_tready = rdy1;
	assign accept   = s_tvalid && rdy1;
	assign fire1    = v1_s1 && rdy2;
	assign fire3    = v3_s3 && rdy4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
		end else begin
			if (rdy1) v1_s1 <= s_tvalid;
			if (rdy2) v2_s2 <= v1_s1;
			if (rdy3) v3_s3 <= v2_s2;
			if (rdy4) v4_s4 <= v3_s3;
		end
	end

	// bin position, frame slot and count of frames already in the memory
	logic [BIN_W-1:0]  bin_q;
	logic [SLOT_W-1:0] slot_q;
	logic [FILL_W-1:0] fill_q;
	logic              last_in;

	assign last_in = (bin_q == BIN_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q  <= '0;
			slot_q <= '0;
			fill_q <= '0;
		end else if (accept) begin
			if (last_in) begin
				bin_q  <= '0;
				slot_q <= (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
				if (fill_q != FILL_FULL) fill_q <= fill_q + 1'b1;
			end else begin
				bin_q <= bin_q + 1'b1;
			end
		end
	end

	// stage 1: input item and the memory row of its bin
	mag_t              voice_s1, back_s1;
	logic [BIN_W-1:0]  bin_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [FILL_W-1:0] fill_s1;
	logic              last_s1;
	logic [ROW_W-1:0]  row_s1;
	logic [ROW_W-1:0]  smooth_mem [BINS];

	always_ff @(posedge clk) begin
		if (rdy1) begin
			voice_s1 <= s_tdata[MAG_W-1:0];
			back_s1  <= s_tdata[2*MAG_W-1:MAG_W];
			bin_s1   <= bin_q;
			slot_s1  <= slot_q;
			fill_s1  <= fill_q;
			last_s1  <= last_in;
			row_s1   <= smooth_mem[bin_q];
		end
	end

	// subtract the weighted background, clamp at zero, merge into the row and sum its filled slots
	logic [MAG_W+GAIN_W-1:0] pos_w, neg_w, diff_w;
	mag_t                    clamped;
	logic [ROW_W-1:0]        row_wr;
	logic [SUM_W-1:0]        bin_sum;

	always_comb begin
		pos_w   = {{(GAIN_W - FRAC_W){1'b0}}, voice_s1, {FRAC_W{1'b0}}};
		neg_w   = (MAG_W + GAIN_W)'(gain_q) * (MAG_W + GAIN_W)'(back_s1);
		diff_w  = pos_w - neg_w;
		clamped = (pos_w > neg_w) ? diff_w[MAG_W+FRAC_W-1:FRAC_W] : '0;
		row_wr  = row_s1;
		bin_sum = '0;
		for (int j = 0; j < AVG_FRAMES; j++) begin
			if (SLOT_W'(j) == slot_s1) begin
				row_wr[j*MAG_W +: MAG_W] = clamped;
				bin_sum = bin_sum + SUM_W'(clamped);
			end else if (FILL_W'(j) < fill_s1) begin
				bin_sum = bin_sum + SUM_W'(row_s1[j*MAG_W +: MAG_W]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire1) smooth_mem[bin_s1] <= row_wr;
	end

	// stage 2: frame sum of the bin, divide by AVG_FRAMES
	logic [SUM_W-1:0]  sum_s2;
	logic              last_s2;
	logic [PROD_W-1:0] prod;
	mag_t              smoothed;

	always_ff @(posedge clk) begin
		if (rdy2) begin
			sum_s2  <= bin_sum;
			last_s2 <= last_s1;
		end
	end

	assign prod     = PROD_W'(sum_s2) * PROD_W'(RECIP);
	assign smoothed = prod[RECIP_SH +: MAG_W];

	// stage 3: frame power and the running window sums
	mag_t              smooth_s3;
	logic              last_s3;
	power_t            acc_q;
	power_t            hist_q [HISTORY_FRAMES];
	logic [WIN_W-1:0]  lead_q, mid_q, trail_q;
	logic [POWER_W:0]  acc_sum;
	power_t            power_now;
	logic [WIN_W-1:0]  lead_nx, mid_nx, trail_nx;
	logic              trig_now;

	always_ff @(posedge clk) begin
		if (rdy3) begin
			smooth_s3 <= smoothed;
			last_s3   <= last_s2;
		end
	end

	always_comb begin
		acc_sum   = {1'b0, acc_q} + (POWER_W + 1)'(smooth_s3);
		power_now = acc_sum[POWER_W] ? '1 : acc_sum[POWER_W-1:0];
		// shift one frame in: each window gains its new head and drops its old tail
		lead_nx   = lead_q + WIN_W'(hist_q[LEAD_END]) - WIN_W'(hist_q[0]);
		mid_nx    = mid_q + WIN_W'(hist_q[MID_END]) - WIN_W'(hist_q[LEAD_END]);
		trail_nx  = trail_q + WIN_W'(power_now) - WIN_W'(hist_q[MID_END]);
		// saturating the sums would not change these compares
		trig_now  = last_s3
			&& (CMP_W'(lead_nx) < CMP_W'(silence_thr_q))
			&& (CMP_W'(mid_nx) >= CMP_W'(sound_thr_q))
			&& (CMP_W'(trail_nx) < CMP_W'(silence_thr_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			lead_q  <= '0;
			mid_q   <= '0;
			trail_q <= '0;
			for (int t = 0; t < HISTORY_FRAMES; t++) hist_q[t] <= '0;
		end else if (fire3) begin
			if (last_s3) begin
				acc_q <= '0;
				if (trig_now) begin
					// drop the whole history after a detection
					lead_q  <= '0;
					mid_q   <= '0;
					trail_q <= '0;
					for (int t = 0; t < HISTORY_FRAMES; t++) hist_q[t] <= '0;
				end else begin
					lead_q  <= lead_nx;
					mid_q   <= mid_nx;
					trail_q <= trail_nx;
					for (int t = 0; t < HISTORY_FRAMES - 1; t++) hist_q[t] <= hist_q[t+1];
					hist_q[HISTORY_FRAMES-1] <= power_now;
				end
			end else begin
				acc_q <= power_now;
			end
		end
	end

	// stage 4: result register
	mag_t   bin_s4;
	power_t power_s4;
	logic   last_s4, trig_s4;

	always_ff @(posedge clk) begin
		if (rdy4) begin
			bin_s4   <= smooth_s3;
			power_s4 <= last_s3 ? power_now : '0;
			last_s4  <= last_s3;
			trig_s4  <= trig_now;
		end
	end

	assign m_tvalid = v4_s4;
	assign m_tdata  = {power_s4, bin_s4};
	assign m_tlast  = last_s4;
	assign m_tuser  = trig_s4;

	// checks
	a_trig_at_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		(v4_s4 && trig_s4) |-> last_s4)
		else $error("trigger outside a frame end");

	a_power_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(v4_s4 && !last_s4) |-> (power_s4 == '0))
		else $error("frame power away from frame end");

	a_clear_on_trigger: assert property (@(posedge clk) disable iff (!arst_n)
		(fire3 && trig_now) |=> (lead_q == '0 && mid_q == '0 && trail_q == '0
			&& acc_q == '0))
		else $error("window sums not cleared after trigger");

	a_bin_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_in) |=> (bin_q == '0 && $past(slot_q) != slot_q))
		else $error("bin counter or slot did not advance at frame end");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != FILL_FULL) |-> (FILL_W'(slot_q) == fill_q))
		else $error("frame fill count out of step with slot");

endmodule
